// ===== design/afit_pkg.sv =====
// Shared types and constants for the aspect-fit texture matrix block.
// No dependencies; every other design file except afit_div imports this package.
package afit_pkg;

    localparam int SIZE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int FIELD_W       = 16;
    localparam int SCALE_W       = 47;
    localparam int OFF_W         = 48;
    localparam int DEG_LIMIT     = 10000;
    localparam int DEG_LIMIT_W   = 14;
    localparam int QUEUE_DEPTH   = 4;

    typedef struct packed {
        logic [FIELD_W-1:0] image_width;
        logic [FIELD_W-1:0] image_height;
        logic [FIELD_W-1:0] rect_width;
        logic [FIELD_W-1:0] rect_height;
    } in_item_t;

    typedef struct packed {
        logic [SCALE_W-1:0]       scale_x;
        logic [SCALE_W-1:0]       scale_y;
        logic signed [OFF_W-1:0]  offset_x;
        logic signed [OFF_W-1:0]  offset_y;
        logic                     degenerate;
    } result_t;

    // Classification that travels with an item from front to back
    typedef struct packed {
        logic wide;    // rect width >= rect height
        logic fit_x;   // rect ratio >= image ratio, fit on x axis
        logic deg;     // kept extent below the limit
    } fit_ctl_t;

endpackage

// ===== design/aspect_fit_texture_matrix.sv =====
// Top level of the aspect-fit texture matrix block.
// Depends on afit_pkg, afit_front, afit_back (and afit_div below it).
//
// Usage: drive item with image and rectangle sizes and raise start; the item
// is taken at a rising edge where start is high and busy is low. Sizes of
// zero count as one. Each item yields one result: done is high for exactly
// one cycle with the matrix on result, and the receiver cannot hold it off.
// An item passes through the cross-product registers, the operand queue, the
// operand register, the pipelined dividers and the output register.
// Throughput is one item per cycle; busy only rises if the operand queue
// could fill, which the back end drains every cycle.
// Reset clears all valid state and the queue; items in flight are dropped.
module aspect_fit_texture_matrix #(
    parameter int SIZE_BITS = afit_pkg::SIZE_BITS_DEF,
    parameter int FRAC_BITS = afit_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  afit_pkg::in_item_t  item,
    output logic                done,
    output afit_pkg::result_t   result
);
    import afit_pkg::*;

    localparam int NW = 2 * SIZE_BITS;
    localparam int DW = 2 * SIZE_BITS + 1;

    logic          q_valid;
    fit_ctl_t      q_ctl;
    logic [NW-1:0] q_n0, q_n1, q_n2;
    logic [DW-1:0] q_d0, q_d1, q_d2;

    afit_front #(.SIZE_BITS(SIZE_BITS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .busy    (busy),
        .q_valid (q_valid),
        .q_ctl   (q_ctl),
        .q_n0    (q_n0),
        .q_d0    (q_d0),
        .q_n1    (q_n1),
        .q_d1    (q_d1),
        .q_n2    (q_n2),
        .q_d2    (q_d2)
    );

    afit_back #(.SIZE_BITS(SIZE_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ctl   (q_ctl),
        .q_n0    (q_n0),
        .q_d0    (q_d0),
        .q_n1    (q_n1),
        .q_d1    (q_d1),
        .q_n2    (q_n2),
        .q_d2    (q_d2),
        .done    (done),
        .result  (result)
    );

endmodule

// ===== design/afit_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
// Gives floor(num * 2^(FRAC_BITS+1) / den). Depends on nothing else.
module afit_div #(
    parameter int NW        = 32,
    parameter int DW        = 33,
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic [NW-1:0]             num,
    input  logic [DW-1:0]             den,
    output logic [NW+FRAC_BITS:0]     quo
);
    localparam int QW = NW + FRAC_BITS + 1;

    logic [DW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] dvd_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] dvd_in;
        logic [QW-1:0] quo_in;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign den_in = den;
            assign dvd_in = {num, {(FRAC_BITS + 1){1'b0}}};
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign dvd_in = dvd_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = {rem_in, dvd_in[QW-1]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
            den_reg[k] <= den_in;
            dvd_reg[k] <= {dvd_in[QW-2:0], 1'b0};
            quo_reg[k] <= {quo_in[QW-2:0], ge};
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

// ===== design/afit_front.sv =====
// Front part: takes items, clamps sizes, forms cross products, classifies
// the fit and queues divider operands. Depends on afit_pkg.
module afit_front #(
    parameter int SIZE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  afit_pkg::in_item_t         item,
    output logic                       busy,
    output logic                       q_valid,
    output afit_pkg::fit_ctl_t         q_ctl,
    output logic [2*SIZE_BITS-1:0]     q_n0,
    output logic [2*SIZE_BITS:0]       q_d0,
    output logic [2*SIZE_BITS-1:0]     q_n1,
    output logic [2*SIZE_BITS:0]       q_d1,
    output logic [2*SIZE_BITS-1:0]     q_n2,
    output logic [2*SIZE_BITS:0]       q_d2
);
    import afit_pkg::*;

    localparam int S   = SIZE_BITS;
    localparam int NW  = 2 * SIZE_BITS;
    localparam int DW  = 2 * SIZE_BITS + 1;
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int MW  = NW + DEG_LIMIT_W;

    function automatic logic [S-1:0] clamp(input logic [FIELD_W-1:0] v);
        logic [S+FIELD_W-1:0] ext;
        logic [S-1:0]         low;
        ext = {{S{1'b0}}, v};
        low = ext[S-1:0];
        return (low == '0) ? S'(1) : low;
    endfunction

    logic          accept;
    logic          f1_valid_reg;
    logic [S-1:0]  iw_reg, ih_reg, sw_reg, sh_reg;
    logic [NW-1:0] a_reg, b_reg;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            iw_reg <= clamp(item.image_width);
            ih_reg <= clamp(item.image_height);
            sw_reg <= clamp(item.rect_width);
            sh_reg <= clamp(item.rect_height);
            a_reg  <= NW'(clamp(item.image_width)) * NW'(clamp(item.rect_height));
            b_reg  <= NW'(clamp(item.image_height)) * NW'(clamp(item.rect_width));
        end
    end

    // Classify and pick operands
    fit_ctl_t      c_ctl;
    logic [NW-1:0] small_v, big_v;
    logic [MW-1:0] small_scaled;
    logic [NW-1:0] c_n0, c_n1, c_n2;
    logic [DW-1:0] c_d0, c_d1, c_d2;

    always_comb
    begin
        c_ctl.wide   = sw_reg >= sh_reg;
        c_ctl.fit_x  = b_reg >= a_reg;
        small_v      = c_ctl.fit_x ? a_reg : b_reg;
        big_v        = c_ctl.fit_x ? b_reg : a_reg;
        small_scaled = MW'(small_v) * MW'(DEG_LIMIT);
        c_ctl.deg    = small_scaled < MW'(big_v);
        c_n0 = NW'(c_ctl.wide ? sw_reg : sh_reg);
        c_d0 = DW'(c_ctl.wide ? sh_reg : sw_reg);
        if (c_ctl.fit_x)
        begin
            c_n1 = c_ctl.wide ? b_reg : NW'(ih_reg);
            c_d1 = c_ctl.wide ? DW'(a_reg) : DW'(iw_reg);
        end
        else
        begin
            c_n1 = c_ctl.wide ? NW'(iw_reg) : a_reg;
            c_d1 = c_ctl.wide ? DW'(ih_reg) : DW'(b_reg);
        end
        c_n2 = big_v - small_v;
        c_d2 = {small_v, 1'b0};
    end

    // Operand queue
    fit_ctl_t      ctl_mem [QUEUE_DEPTH];
    logic [NW-1:0] n0_mem [QUEUE_DEPTH];
    logic [NW-1:0] n1_mem [QUEUE_DEPTH];
    logic [NW-1:0] n2_mem [QUEUE_DEPTH];
    logic [DW-1:0] d0_mem [QUEUE_DEPTH];
    logic [DW-1:0] d1_mem [QUEUE_DEPTH];
    logic [DW-1:0] d2_mem [QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign push = f1_valid_reg;
    assign pop  = count_reg != '0;

    always_comb
    begin
        wr_ptr_next = push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = CW'(count_reg + CW'(push) - CW'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_mem[wr_ptr_reg] <= c_ctl;
            n0_mem[wr_ptr_reg]  <= c_n0;
            n1_mem[wr_ptr_reg]  <= c_n1;
            n2_mem[wr_ptr_reg]  <= c_n2;
            d0_mem[wr_ptr_reg]  <= c_d0;
            d1_mem[wr_ptr_reg]  <= c_d1;
            d2_mem[wr_ptr_reg]  <= c_d2;
        end
    end

    // Hold off new items when the queue could overflow
    assign busy = (CW'(count_reg) + CW'(f1_valid_reg)) >= CW'(QUEUE_DEPTH - 1);

    assign q_valid = pop;
    assign q_ctl   = ctl_mem[rd_ptr_reg];
    assign q_n0    = n0_mem[rd_ptr_reg];
    assign q_n1    = n1_mem[rd_ptr_reg];
    assign q_n2    = n2_mem[rd_ptr_reg];
    assign q_d0    = d0_mem[rd_ptr_reg];
    assign q_d1    = d1_mem[rd_ptr_reg];
    assign q_d2    = d2_mem[rd_ptr_reg];

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_accept_f1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> f1_valid_reg)
        else $error("accepted item lost before classify");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> count_reg < CW'(QUEUE_DEPTH))
        else $error("push into full queue");
`endif

endmodule

// ===== design/afit_back.sv =====
// Back part: runs the three divisions, rounds, saturates and assembles the
// result item. Depends on afit_pkg and afit_div.
module afit_back #(
    parameter int SIZE_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  afit_pkg::fit_ctl_t         q_ctl,
    input  logic [2*SIZE_BITS-1:0]     q_n0,
    input  logic [2*SIZE_BITS:0]       q_d0,
    input  logic [2*SIZE_BITS-1:0]     q_n1,
    input  logic [2*SIZE_BITS:0]       q_d1,
    input  logic [2*SIZE_BITS-1:0]     q_n2,
    input  logic [2*SIZE_BITS:0]       q_d2,
    output logic                       done,
    output afit_pkg::result_t          result
);
    import afit_pkg::*;

    localparam int NW = 2 * SIZE_BITS;
    localparam int DW = 2 * SIZE_BITS + 1;
    localparam int QW = NW + FRAC_BITS + 1;
    localparam int MW = (QW > OFF_W) ? QW : OFF_W;
    localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};
    localparam logic [SCALE_W-1:0] UNIT = SCALE_W'(1) << FRAC_BITS;

    function automatic logic [SCALE_W-1:0] round_sat(input logic [QW-1:0] q);
        logic [MW-1:0] r;
        r = MW'(q[QW-1:1]) + MW'(q[0]);
        return (r > MW'(SCALE_MAX)) ? SCALE_MAX : r[SCALE_W-1:0];
    endfunction

    logic          in_valid_reg;
    fit_ctl_t      in_ctl_reg;
    logic [NW-1:0] n0_reg, n1_reg, n2_reg;
    logic [DW-1:0] d0_reg, d1_reg, d2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        in_ctl_reg <= q_ctl;
        n0_reg     <= q_n0;
        n1_reg     <= q_n1;
        n2_reg     <= q_n2;
        d0_reg     <= q_d0;
        d1_reg     <= q_d1;
        d2_reg     <= q_d2;
    end

    logic [QW-1:0] quo0, quo1, quo2;

    afit_div #(.NW(NW), .DW(DW), .FRAC_BITS(FRAC_BITS)) u_div_base (
        .clk (clk), .num (n0_reg), .den (d0_reg), .quo (quo0)
    );
    afit_div #(.NW(NW), .DW(DW), .FRAC_BITS(FRAC_BITS)) u_div_scale (
        .clk (clk), .num (n1_reg), .den (d1_reg), .quo (quo1)
    );
    afit_div #(.NW(NW), .DW(DW), .FRAC_BITS(FRAC_BITS)) u_div_off (
        .clk (clk), .num (n2_reg), .den (d2_reg), .quo (quo2)
    );

    // Carry valid and classification alongside the divider stages
    logic     vld_pipe_reg [QW];
    fit_ctl_t ctl_pipe_reg [QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                vld_pipe_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_pipe_reg[0] <= in_valid_reg;
            for (int k = 1; k < QW; k++)
            begin
                vld_pipe_reg[k] <= vld_pipe_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_pipe_reg[0] <= in_ctl_reg;
        for (int k = 1; k < QW; k++)
        begin
            ctl_pipe_reg[k] <= ctl_pipe_reg[k-1];
        end
    end

    fit_ctl_t           fctl;
    logic [SCALE_W-1:0] base_v, fit_v, off_mag, bx, by;
    logic [OFF_W-1:0]   off_neg;
    result_t            res_next, res_reg;
    logic               done_reg;

    always_comb
    begin
        fctl    = ctl_pipe_reg[QW-1];
        base_v  = round_sat(quo0);
        fit_v   = round_sat(quo1);
        off_mag = round_sat(quo2);
        off_neg = OFF_W'(0) - {1'b0, off_mag};
        bx      = fctl.wide ? UNIT : base_v;
        by      = fctl.wide ? base_v : UNIT;
        res_next.scale_x    = bx;
        res_next.scale_y    = by;
        res_next.offset_x   = '0;
        res_next.offset_y   = '0;
        res_next.degenerate = fctl.deg;
        if (!fctl.deg)
        begin
            if (fctl.fit_x)
            begin
                res_next.scale_x  = fit_v;
                res_next.offset_x = off_neg;
            end
            else
            begin
                res_next.scale_y  = fit_v;
                res_next.offset_y = off_neg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_pipe_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

`ifndef ASSERT_OFF
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(vld_pipe_reg[QW-1]))
        else $error("result strobe without item in last stage");
    a_deg_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.degenerate) |-> (res_reg.offset_x == '0 && res_reg.offset_y == '0))
        else $error("degenerate result carries an offset");
    a_one_offset: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (res_reg.offset_x == '0 || res_reg.offset_y == '0))
        else $error("both offsets nonzero");
`endif

endmodule
